// ===== rtl/sorted_range_node_packer_top_defines.svh =====
// ---------------------------------------------------------------------------
// Sorted range node packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_NODE_PACKER_TOP_DEFINES_SVH
`define SORTED_RANGE_NODE_PACKER_TOP_DEFINES_SVH

// same-cycle implication
`define SRNP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srnp_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted range node packer package
// Item types, mode and status codes, default index width.
// ---------------------------------------------------------------------------
`default_nettype none

package srnp_pkg;

  localparam int unsigned INDEX_WIDTH_DEF = 31;
  localparam int unsigned FIELD_W         = 31;

  typedef enum logic [0:0] {
    MODE_ADD   = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_EMIT     = 2'd0,
    ST_ORDER    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_length;
  } range_item_t;

  typedef struct packed {
    status_t            status;
    logic               node_is_pair;
    logic [FIELD_W-1:0] node_high;
    logic [FIELD_W-1:0] node_extra;
  } node_item_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_range_node_packer_top.sv =====
// ---------------------------------------------------------------------------
// Sorted range node packer
// Packs ascending element ranges into range and pair nodes, emitting each
// finished node, with order and overflow reporting.
// ---------------------------------------------------------------------------
// One range item is taken every cycle unless the output stalls. Each item
// is checked and merged into the held node in the cycle it is accepted;
// any resulting node or error item appears in the output register on the
// next cycle and waits there while node_ready is low. The held node update
// sets the rate of one item per clock. A flush with no node held and a
// range absorbed into the held node produce no output item.
`default_nettype none

module sorted_range_node_packer_top #(
  parameter int unsigned INDEX_WIDTH = srnp_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  range_valid,
  output logic                       range_ready,
  input  wire srnp_pkg::range_item_t range_item,
  output logic                       node_valid,
  input  wire logic                  node_ready,
  output srnp_pkg::node_item_t       node_item
);

  import srnp_pkg::*;

  `include "sorted_range_node_packer_top_defines.svh"

  localparam logic [FIELD_W:0] LIMIT = (INDEX_WIDTH >= FIELD_W) ?
    {1'b0, {FIELD_W{1'b1}}} : (({{FIELD_W{1'b0}}, 1'b1} << INDEX_WIDTH) - 1'b1);

  logic               held_valid, held_valid_next;
  logic               held_is_pair, held_is_pair_next;
  logic [FIELD_W-1:0] held_high, held_high_next;
  logic [FIELD_W-1:0] held_extra, held_extra_next;

  logic [FIELD_W-1:0] lo, top, end_lo, span2;
  logic [FIELD_W:0]   end_full, high_p1;
  logic               accept, emit, order_err, ovf_err, adj_pair;
  node_item_t         res;

  assign range_ready = !node_valid || node_ready;
  assign accept      = range_valid && range_ready;

  assign end_full = {1'b0, range_item.range_start} + {1'b0, range_item.range_length};
  assign end_lo   = end_full[FIELD_W-1:0];
  assign high_p1  = {1'b0, held_high} + 1'b1;
  assign adj_pair = (held_extra != '0) && ({1'b0, held_high} == {1'b0, held_extra} + 1'b1);
  assign span2    = end_lo - top - 1'b1;

  always_comb begin
    if (!held_is_pair) begin
      lo  = held_high - held_extra;
      top = held_high;
    end else if (adj_pair) begin
      lo  = held_extra;
      top = held_high;
    end else begin
      lo  = held_high;
      top = held_high;
    end
  end

  assign order_err = (range_item.range_start == '0) ||
                     (held_valid && (range_item.range_start < lo));
  assign ovf_err   = end_full > LIMIT;

  always_comb begin
    held_valid_next   = held_valid;
    held_is_pair_next = held_is_pair;
    held_high_next    = held_high;
    held_extra_next   = held_extra;
    emit              = 1'b0;
    res               = '0;
    res.status        = ST_EMIT;
    if (range_item.mode == MODE_FLUSH) begin
      if (held_valid) begin
        emit              = 1'b1;
        res.node_is_pair  = held_is_pair;
        res.node_high     = held_high;
        res.node_extra    = held_extra;
        held_valid_next   = 1'b0;
        held_is_pair_next = 1'b0;
        held_high_next    = '0;
        held_extra_next   = '0;
      end
    end else if (order_err) begin
      emit       = 1'b1;
      res.status = ST_ORDER;
    end else if (ovf_err) begin
      emit       = 1'b1;
      res.status = ST_OVERFLOW;
    end else if (!held_valid) begin
      held_valid_next   = 1'b1;
      held_is_pair_next = (range_item.range_length == '0);
      held_high_next    = end_lo;
      held_extra_next   = range_item.range_length;
    end else if (range_item.range_start <= top) begin
      if (end_lo > top) begin
        if (!held_is_pair || held_extra == '0) begin
          held_is_pair_next = 1'b0;
          held_extra_next   = held_extra + end_lo - held_high;
          held_high_next    = end_lo;
        end else begin
          emit              = 1'b1;
          res.node_is_pair  = held_is_pair;
          res.node_high     = held_high;
          res.node_extra    = held_extra;
          held_is_pair_next = (span2 == '0);
          held_extra_next   = span2;
          held_high_next    = end_lo;
        end
      end
    end else if ((range_item.range_length == '0) && !held_is_pair &&
                 ({1'b0, range_item.range_start} == high_p1)) begin
      held_high_next  = range_item.range_start;
      held_extra_next = held_extra + 1'b1;
    end else if ((range_item.range_length == '0) && held_is_pair &&
                 (held_extra == '0)) begin
      held_high_next = range_item.range_start;
      if ({1'b0, range_item.range_start} == high_p1) begin
        held_is_pair_next = 1'b0;
        held_extra_next   = {{(FIELD_W-1){1'b0}}, 1'b1};
      end else begin
        held_extra_next = held_high;
      end
    end else begin
      emit              = 1'b1;
      res.node_is_pair  = held_is_pair;
      res.node_high     = held_high;
      res.node_extra    = held_extra;
      held_is_pair_next = (range_item.range_length == '0);
      held_high_next    = end_lo;
      held_extra_next   = range_item.range_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      held_is_pair <= 1'b0;
      held_high    <= '0;
      held_extra   <= '0;
      node_valid   <= 1'b0;
    end else begin
      if (accept) begin
        held_valid   <= held_valid_next;
        held_is_pair <= held_is_pair_next;
        held_high    <= held_high_next;
        held_extra   <= held_extra_next;
        node_valid   <= emit;
      end else if (node_ready) begin
        node_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      node_item <= res;
    end
  end

  `SRNP_ASSERT_NOW(a_range_span, held_valid && !held_is_pair, held_extra <= held_high,
                   "range node span exceeds its high end")
  `SRNP_ASSERT_NOW(a_pair_order, held_valid && held_is_pair && (held_extra != '0),
                   held_extra < held_high, "pair node second element not below high")
  `SRNP_ASSERT_NOW(a_high_limit, held_valid, {1'b0, held_high} <= LIMIT,
                   "held node high above index limit")
  `SRNP_ASSERT_NEXT(a_empty_flush, accept && (range_item.mode == MODE_FLUSH) && !held_valid,
                    !node_valid, "flush with no node held produced an item")
  `SRNP_ASSERT_NOW(a_err_clean, node_valid && (node_item.status != ST_EMIT),
                   (node_item.node_high == '0) && (node_item.node_extra == '0) &&
                   !node_item.node_is_pair, "error item carries node fields")

endmodule

`default_nettype wire

// ===== test/sorted_range_node_packer_top_test.sv =====
// ---------------------------------------------------------------------------
// Sorted range node packer testbench
// Feeds ascending range items, flushes and malformed ranges into the packer
// with random sender bursts and receiver stalls, and checks every node and
// error item against a cycle-free model of the held node.
// ---------------------------------------------------------------------------
module sorted_range_node_packer_top_test;
  import srnp_pkg::*;

  localparam longint unsigned INDEX_MAX = 64'h7FFF_FFFF;
  localparam int unsigned N_ITEMS = 1125;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLDOFF_AT = 600;
  localparam int unsigned HOLDOFF_LEN = 400;

  logic        clk;
  logic        rst;
  logic        range_valid;
  logic        range_ready;
  range_item_t range_item;
  logic        node_valid;
  logic        node_ready;
  node_item_t  node_item;

  sorted_range_node_packer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .range_valid (range_valid),
    .range_ready (range_ready),
    .range_item  (range_item),
    .node_valid  (node_valid),
    .node_ready  (node_ready),
    .node_item   (node_item)
  );

  // held node as the packer should see it
  bit              held_on;
  bit              held_pair;
  longint unsigned held_hi;
  longint unsigned held_ex;

  range_item_t range_backlog[$];
  node_item_t  pending_nodes[$];
  node_item_t  predicted_node;
  node_item_t  want_node;

  int unsigned n_taken, n_emitted, n_order, n_overflow, n_faults;
  int unsigned burst_left, gap_left;
  int unsigned rx_cycle, holdoff_left, phase_left, ready_pct;
  int unsigned cycle_count;

  function automatic node_item_t node_of(status_t st, bit pair, longint unsigned hi,
                                         longint unsigned ex);
    node_item_t n;
    n.status       = st;
    n.node_is_pair = pair;
    n.node_high    = hi[FIELD_W-1:0];
    n.node_extra   = ex[FIELD_W-1:0];
    return n;
  endfunction

  function automatic void hold_span(longint unsigned lo, longint unsigned hi);
    held_on = 1'b1;
    if (lo == hi) begin
      held_pair = 1'b1;
      held_hi   = lo;
      held_ex   = 0;
    end else begin
      held_pair = 1'b0;
      held_hi   = hi;
      held_ex   = hi - lo;
    end
  endfunction

  // returns 1 when the range item gives an output item
  function automatic bit pack_range(range_item_t it, output node_item_t res);
    longint unsigned start, len, stop, lo, top;
    start = it.range_start;
    len   = it.range_length;
    stop  = start + len;
    res   = '0;
    if (it.mode == MODE_FLUSH) begin
      if (!held_on) return 1'b0;
      res       = node_of(ST_EMIT, held_pair, held_hi, held_ex);
      held_on   = 1'b0;
      held_pair = 1'b0;
      held_hi   = 0;
      held_ex   = 0;
      return 1'b1;
    end
    if (!held_on) lo = 0;
    else if (!held_pair) lo = held_hi - held_ex;
    else if (held_ex != 0 && held_hi == held_ex + 1) lo = held_ex;
    else lo = held_hi;
    top = held_hi;
    if (start == 0 || start < lo) begin
      res = node_of(ST_ORDER, 1'b0, 0, 0);
      return 1'b1;
    end
    if (stop > INDEX_MAX) begin
      res = node_of(ST_OVERFLOW, 1'b0, 0, 0);
      return 1'b1;
    end
    if (!held_on) begin
      hold_span(start, stop);
      return 1'b0;
    end
    if (start <= top) begin
      if (stop <= top) return 1'b0;
      if (!held_pair) begin
        held_ex = held_ex + (stop - held_hi);
        held_hi = stop;
        return 1'b0;
      end
      if (held_ex == 0) begin
        hold_span(held_hi, stop);
        return 1'b0;
      end
      // full pair: new node starts above its high element
      res = node_of(ST_EMIT, held_pair, held_hi, held_ex);
      hold_span(top + 1, stop);
      return 1'b1;
    end
    if (len == 0) begin
      if (!held_pair && start == held_hi + 1) begin
        held_hi = start;
        held_ex = held_ex + 1;
        return 1'b0;
      end
      if (held_pair && held_ex == 0) begin
        held_ex = held_hi;
        held_hi = start;
        if (held_ex + 1 == held_hi) begin
          held_pair = 1'b0;
          held_ex   = 1;
        end
        return 1'b0;
      end
    end
    res = node_of(ST_EMIT, held_pair, held_hi, held_ex);
    hold_span(start, stop);
    return 1'b1;
  endfunction

  task automatic queue_range(mode_t m, longint unsigned s, longint unsigned l);
    range_item_t it;
    it.mode         = m;
    it.range_start  = s[FIELD_W-1:0];
    it.range_length = l[FIELD_W-1:0];
    range_backlog.push_back(it);
  endtask

  task automatic log_fault(string msg);
    if (n_faults < 10) $display("%0t: %s", $realtime, msg);
    n_faults++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    longint unsigned cur, s, l;
    int unsigned pick;
    bit is_flush;
    rst         = 1'b1;
    range_valid = 1'b0;
    range_item  = '0;
    node_ready  = 1'b0;

    queue_range(MODE_FLUSH, 0, 0);
    queue_range(MODE_ADD, 0, 0);
    queue_range(MODE_ADD, INDEX_MAX, 1);
    queue_range(MODE_ADD, 1, INDEX_MAX - 1);
    queue_range(MODE_FLUSH, INDEX_MAX, INDEX_MAX);
    queue_range(MODE_ADD, 100, 0);
    queue_range(MODE_ADD, 101, 0);
    queue_range(MODE_ADD, 102, 0);
    queue_range(MODE_ADD, 100, 1);
    queue_range(MODE_ADD, 99, 0);
    queue_range(MODE_ADD, 101, 5);
    queue_range(MODE_ADD, 107, INDEX_MAX);
    queue_range(MODE_ADD, 0, 3);
    queue_range(MODE_ADD, 200, 0);
    queue_range(MODE_ADD, 205, 0);
    queue_range(MODE_ADD, 205, 3);
    queue_range(MODE_ADD, 300, 0);
    queue_range(MODE_ADD, 310, 0);
    queue_range(MODE_ADD, 320, 0);
    queue_range(MODE_ADD, 320, 4);
    queue_range(MODE_ADD, 330, 7);
    queue_range(MODE_FLUSH, 0, 0);
    queue_range(MODE_ADD, INDEX_MAX, 0);
    queue_range(MODE_FLUSH, 0, 0);
    queue_range(MODE_FLUSH, 0, 0);

    // runs of mostly ascending ranges, each run at a fresh base
    cur = 0;
    while (range_backlog.size() < N_ITEMS) begin
      if (cur == 0 || $urandom_range(0, 1) == 0 || cur > INDEX_MAX - 64'd200000) begin
        queue_range(MODE_FLUSH, $urandom, $urandom);
        case ($urandom_range(0, 3))
          0:       cur = INDEX_MAX - $urandom_range(0, 4000);
          1:       cur = $urandom_range(1, 32'h7FFF_0000);
          default: cur = $urandom_range(1, 1 << 20);
        endcase
      end else begin
        cur = cur + $urandom_range(1, 1 << 16);
      end
      repeat ($urandom_range(1, 30)) begin
        pick     = $urandom_range(0, 99);
        is_flush = 1'b0;
        s        = cur + 1;
        l        = 0;
        if (pick < 30) begin
          l = 0;
        end else if (pick < 45) begin
          s = cur + $urandom_range(2, 5);
        end else if (pick < 60) begin
          s = cur + $urandom_range(1, 8);
          l = $urandom_range(0, 20);
        end else if (pick < 75) begin
          s = (cur > 3) ? cur - $urandom_range(0, 3) : cur;
          l = $urandom_range(0, 10);
        end else if (pick < 80) begin
          s = (cur > 2) ? cur - $urandom_range(0, 2) : cur;
        end else if (pick < 85) begin
          s = $urandom_range(0, int'(cur / 2));
          l = $urandom_range(0, 5);
        end else if (pick < 90) begin
          l = INDEX_MAX - cur + $urandom_range(0, 1000);
        end else if (pick < 95) begin
          s = $urandom_range(1, 64);
          l = $urandom & INDEX_MAX;
        end else begin
          is_flush = 1'b1;
        end
        if (s > INDEX_MAX) s = INDEX_MAX;
        if (l > INDEX_MAX) l = INDEX_MAX;
        if (is_flush) begin
          queue_range(MODE_FLUSH, $urandom, $urandom);
        end else begin
          queue_range(MODE_ADD, s, l);
          if (pick < 80 && s + l <= INDEX_MAX && s + l > cur) cur = s + l;
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (range_backlog.size() != 0 || range_valid) @(posedge clk);
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d range items; got %0d nodes, %0d order and %0d overflow reports.",
             n_taken, n_emitted, n_order, n_overflow);
    $display("Faults found: %0d.", n_faults);
    if (n_faults == 0) begin
      $display("sorted_range_node_packer_top_test OK");
    end else begin
      $display("sorted_range_node_packer_top_test NOT OK");
    end
    $finish;
  end

  // sender: bursts of items with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      range_valid <= 1'b0;
    end else begin
      if (range_valid && range_ready) begin
        if (pack_range(range_item, predicted_node)) pending_nodes.push_back(predicted_node);
        n_taken++;
      end
      if (!range_valid || range_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          range_valid <= 1'b0;
        end else if (range_backlog.size() != 0) begin
          range_valid <= 1'b1;
          range_item  <= range_backlog.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          range_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall density changes per stretch, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      node_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HOLDOFF_AT) holdoff_left = HOLDOFF_LEN;
      if (holdoff_left != 0) begin
        holdoff_left--;
        node_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 60);
          case ($urandom_range(0, 2))
            0:       ready_pct = 100;
            1:       ready_pct = 70;
            default: ready_pct = 30;
          endcase
        end
        phase_left--;
        node_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && node_valid && node_ready) begin
      case (node_item.status)
        ST_EMIT:     n_emitted++;
        ST_ORDER:    n_order++;
        ST_OVERFLOW: n_overflow++;
        default:     ;
      endcase
      if (pending_nodes.size() == 0) begin
        log_fault($sformatf("unexpected node item: status %0d pair %0d high %h extra %h",
                            node_item.status, node_item.node_is_pair,
                            node_item.node_high, node_item.node_extra));
      end else begin
        want_node = pending_nodes.pop_front();
        if (node_item.status !== want_node.status
            || node_item.node_is_pair !== want_node.node_is_pair
            || node_item.node_high !== want_node.node_high
            || node_item.node_extra !== want_node.node_extra) begin
          log_fault($sformatf({"node item mismatch: want status %0d pair %0d high %h ",
                               "extra %h, got status %0d pair %0d high %h extra %h"},
                              want_node.status, want_node.node_is_pair,
                              want_node.node_high, want_node.node_extra,
                              node_item.status, node_item.node_is_pair,
                              node_item.node_high, node_item.node_extra));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d items queued and %0d results pending.",
               range_backlog.size(), pending_nodes.size());
      $display("sorted_range_node_packer_top_test NOT OK");
      $finish;
    end
  end

endmodule

// ===== sorted_range_node_packer_top.f =====
+incdir+rtl
rtl/srnp_pkg.sv
rtl/sorted_range_node_packer_top.sv
test/sorted_range_node_packer_top_test.sv
